@@ rtl/pwc_pkg.sv @@
// Shared types, codes and constants for the PSF window clip pipeline.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package pwc_pkg;

    localparam int DEF_IMAGE_COLS = 1024;
    localparam int DEF_IMAGE_ROWS = 1024;

    // Doubled-unit numerators stay below 2**34, doubled pitches below 2**32.
    localparam int NUM_W   = 34;
    localparam int DEN_W   = 32;
    localparam int LANES   = 4;
    localparam int CASE_W  = 3;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 32;

    typedef enum logic [CASE_W-1:0] {
        CASE_CORNER = 3'd0,
        CASE_INSIDE = 3'd1,
        CASE_LEFT   = 3'd2,
        CASE_BOTTOM = 3'd3,
        CASE_NONE   = 3'd4
    } pwc_case_t;

    typedef enum logic [CFG_A_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_PITCH_X    = 3'd2,
        REG_PITCH_Y    = 3'd3,
        REG_PSF_COLS   = 3'd4,
        REG_PSF_ROWS   = 3'd5,
        REG_PSF_WIDTH  = 3'd6,
        REG_PSF_HEIGHT = 3'd7
    } pwc_reg_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [30:0]        pitch_x;
        logic [30:0]        pitch_y;
        logic [8:0]         psf_cols;
        logic [8:0]         psf_rows;
        logic [30:0]        psf_width;
        logic [30:0]        psf_height;
    } pwc_cfg_t;

    typedef logic [LANES-1:0][NUM_W-1:0] pwc_num_t;

endpackage

`default_nettype wire

@@ rtl/pwc_front.sv @@
// Input stage: doubled distances, window tests, case code and divider numerators.
// Depends on pwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwc_front
    import pwc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pwc_cfg_t           cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pwc_num_t                num,
    output logic [CASE_W-1:0]       kind
);

    logic               valid_reg;
    pwc_num_t           num_reg;
    pwc_num_t           num_next;
    pwc_case_t          kind_reg;
    pwc_case_t          kind_next;
    logic               en;
    logic signed [35:0] xz2;
    logic signed [35:0] yz2;
    logic signed [35:0] w;
    logic signed [35:0] h;
    logic signed [35:0] sx_a;
    logic signed [35:0] sx_b;
    logic signed [35:0] sy_a;
    logic signed [35:0] sy_b;
    logic               x_in;
    logic               y_in;
    logic               x_lo;
    logic               y_lo;

    always_comb
    begin
        xz2 = (36'(cfg.origin_x) - 36'(pos_x)) <<< 1;
        yz2 = (36'(cfg.origin_y) - 36'(pos_y)) <<< 1;
        w   = $signed({5'd0, cfg.psf_width});
        h   = $signed({5'd0, cfg.psf_height});
        x_in = (-w < xz2) && (xz2 < w);
        y_in = (-h < yz2) && (yz2 < h);
        x_lo = xz2 < -w;
        y_lo = yz2 < -h;
        sx_a = x_lo ? (-w - xz2) : (xz2 + w);
        sx_b = w - xz2;
        sy_a = y_lo ? (-h - yz2) : (yz2 + h);
        sy_b = h - yz2;
        num_next[0] = sx_a[NUM_W-1:0];
        num_next[1] = sx_b[NUM_W-1:0];
        num_next[2] = sy_a[NUM_W-1:0];
        num_next[3] = sy_b[NUM_W-1:0];
        if (x_in && y_in)
            kind_next = CASE_CORNER;
        else if (x_lo && y_lo)
            kind_next = CASE_INSIDE;
        else if (x_in && y_lo)
            kind_next = CASE_LEFT;
        else if (x_lo && y_in)
            kind_next = CASE_BOTTOM;
        else
            kind_next = CASE_NONE;
    end

    assign en       = !valid_reg || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            num_reg  <= num_next;
            kind_reg <= kind_next;
        end
    end

    assign out_valid = valid_reg;
    assign num       = num_reg;
    assign kind      = kind_reg;

endmodule

`default_nettype wire

@@ rtl/pwc_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, several lanes in step.
// Depends on pwc_pkg for its parameter defaults; carries a sideband word.
`timescale 1ns / 1ps
`default_nettype none

module pwc_div_pipe
    import pwc_pkg::*;
#(
    parameter int N_W  = NUM_W,
    parameter int D_W  = DEN_W,
    parameter int NL   = LANES,
    parameter int SB_W = CASE_W
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [NL-1:0][D_W-1:0]   den,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [NL-1:0][N_W-1:0]   num,
    input  wire logic [SB_W-1:0]          sb_in,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [NL-1:0][N_W-1:0]        quo,
    output logic [SB_W-1:0]               sb_out
);

    logic [N_W-1:0]                  v_reg;
    logic [N_W-1:0]                  en;
    logic [N_W-1:0][NL-1:0][D_W-1:0] rem_reg;
    logic [N_W-1:0][NL-1:0][D_W-1:0] rem_next;
    logic [N_W-1:0][NL-1:0][N_W-1:0] nq_reg;
    logic [N_W-1:0][NL-1:0][N_W-1:0] nq_next;
    logic [N_W-1:0][SB_W-1:0]        sb_reg;
    logic [D_W:0]                    trial;
    logic [D_W:0]                    diff;
    logic [D_W-1:0]                  rem_src;
    logic [N_W-1:0]                  nq_src;
    logic                            ge;

    always_comb
    begin
        en[N_W-1] = !v_reg[N_W-1] || !out_stall;
        for (int k = N_W - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    always_comb
    begin
        trial   = '0;
        diff    = '0;
        rem_src = '0;
        nq_src  = '0;
        ge      = 1'b0;
        for (int k = 0; k < N_W; k++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                if (k == 0)
                begin
                    rem_src = '0;
                    nq_src  = num[l];
                end
                else
                begin
                    rem_src = rem_reg[k-1][l];
                    nq_src  = nq_reg[k-1][l];
                end
                trial = {rem_src, nq_src[N_W-1]};
                diff  = trial - {1'b0, den[l]};
                ge    = trial >= {1'b0, den[l]};
                rem_next[k][l] = ge ? diff[D_W-1:0] : trial[D_W-1:0];
                nq_next[k][l]  = {nq_src[N_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < N_W; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            rem_reg[0] <= rem_next[0];
            nq_reg[0]  <= nq_next[0];
            sb_reg[0]  <= sb_in;
        end
        for (int k = 1; k < N_W; k++)
        begin
            if (en[k] && v_reg[k-1])
            begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                sb_reg[k]  <= sb_reg[k-1];
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[N_W-1];
    assign quo       = nq_reg[N_W-1];
    assign sb_out    = sb_reg[N_W-1];

endmodule

`default_nettype wire

@@ rtl/pwc_back.sv @@
// Output stages: clamp and scale the quotients, then form offsets and spans by case.
// Depends on pwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwc_back
    import pwc_pkg::*;
#(
    parameter int IMAGE_COLS = DEF_IMAGE_COLS,
    parameter int IMAGE_ROWS = DEF_IMAGE_ROWS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pwc_cfg_t      cfg,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire pwc_num_t      quo,
    input  wire logic [CASE_W-1:0] kind,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [19:0]        image_offset,
    output logic [15:0]        psf_index,
    output logic [10:0]        span_cols,
    output logic [10:0]        span_rows,
    output logic [CASE_W-1:0]  overlap_case
);

    localparam int PI_W = 21 + $clog2(IMAGE_COLS + 1);

    function automatic logic [10:0] clamp_span(input logic signed [35:0] v);
        logic [10:0] r;
        if (v < 0)
            r = '0;
        else if (v > 36'sd2047)
            r = '1;
        else
            r = v[10:0];
        return r;
    endfunction

    function automatic logic [10:0] span_limit(input logic [NUM_W-1:0] start,
                                               input logic [8:0] n,
                                               input logic signed [35:0] lim);
        logic signed [35:0] s;
        logic signed [35:0] ne;
        logic signed [35:0] r;
        s  = $signed({2'b00, start});
        ne = $signed({27'd0, n});
        if (s + ne > lim)
            r = lim - s;
        else
            r = ne;
        return clamp_span(r);
    endfunction

    logic              v1_reg;
    logic              v2_reg;
    logic              en1;
    logic              en2;
    pwc_case_t         kind_in;
    pwc_case_t         kind1_reg;
    pwc_case_t         kind2_reg;
    logic [16:0]       ii17;
    logic [20:0]       ii21;
    logic [20:0]       jj21;
    logic [25:0]       prod_p_next;
    logic [25:0]       prod_p_reg;
    logic [PI_W-1:0]   prod_i_next;
    logic [PI_W-1:0]   prod_i_reg;
    logic [20:0]       jj_reg;
    logic [10:0]       nj_next;
    logic [10:0]       ni_next;
    logic [10:0]       nj1_reg;
    logic [10:0]       ni1_reg;
    logic [10:0]       nj2_reg;
    logic [10:0]       ni2_reg;
    logic [26:0]       psf_sum;
    logic [PI_W:0]     img_sum;
    logic [15:0]       psf_next;
    logic [19:0]       img_next;
    logic [15:0]       psf_reg;
    logic [19:0]       img_reg;

    assign kind_in = pwc_case_t'(kind);

    always_comb
    begin
        ii17 = (|quo[2][NUM_W-1:17]) ? '1 : quo[2][16:0];
        ii21 = (|quo[2][NUM_W-1:21]) ? '1 : quo[2][20:0];
        jj21 = (|quo[0][NUM_W-1:21]) ? '1 : quo[0][20:0];
        prod_p_next = 26'(ii17) * 26'(cfg.psf_cols);
        prod_i_next = PI_W'(ii21) * PI_W'(IMAGE_COLS);
        case (kind_in)
            CASE_CORNER:
            begin
                nj_next = clamp_span($signed({2'b00, quo[1]}));
                ni_next = clamp_span($signed({2'b00, quo[3]}));
            end
            CASE_INSIDE:
            begin
                nj_next = span_limit(quo[0], cfg.psf_cols, 36'(IMAGE_COLS));
                ni_next = span_limit(quo[2], cfg.psf_rows, 36'(IMAGE_ROWS));
            end
            CASE_LEFT:
            begin
                nj_next = clamp_span($signed({27'd0, cfg.psf_cols})
                                     - $signed({2'b00, quo[0]}));
                ni_next = span_limit(quo[2], cfg.psf_rows, 36'(IMAGE_ROWS));
            end
            CASE_BOTTOM:
            begin
                nj_next = span_limit(quo[0], cfg.psf_cols, 36'(IMAGE_COLS));
                ni_next = clamp_span($signed({27'd0, cfg.psf_rows})
                                     - $signed({2'b00, quo[2]}));
            end
            default:
            begin
                nj_next = '0;
                ni_next = '0;
            end
        endcase
    end

    always_comb
    begin
        psf_sum = 27'(prod_p_reg) + 27'(jj_reg);
        img_sum = (PI_W + 1)'(prod_i_reg) + (PI_W + 1)'(jj_reg);
        case (kind1_reg)
            CASE_CORNER:
            begin
                psf_next = (psf_sum > 27'd65535) ? '1 : psf_sum[15:0];
                img_next = '0;
            end
            CASE_INSIDE:
            begin
                psf_next = '0;
                img_next = (img_sum > (PI_W + 1)'(1048575)) ? '1 : img_sum[19:0];
            end
            CASE_LEFT:
            begin
                psf_next = (jj_reg > 21'd65535) ? '1 : jj_reg[15:0];
                img_next = (prod_i_reg > PI_W'(1048575)) ? '1 : prod_i_reg[19:0];
            end
            CASE_BOTTOM:
            begin
                psf_next = (prod_p_reg > 26'd65535) ? '1 : prod_p_reg[15:0];
                img_next = (jj_reg > 21'd1048575) ? '1 : jj_reg[19:0];
            end
            default:
            begin
                psf_next = '0;
                img_next = '0;
            end
        endcase
    end

    assign en2      = !v2_reg || !out_stall;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            kind1_reg  <= kind_in;
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            jj_reg     <= jj21;
            nj1_reg    <= nj_next;
            ni1_reg    <= ni_next;
        end
        if (en2 && v1_reg)
        begin
            kind2_reg <= kind1_reg;
            psf_reg   <= psf_next;
            img_reg   <= img_next;
            nj2_reg   <= nj1_reg;
            ni2_reg   <= ni1_reg;
        end
    end

    assign out_valid    = v2_reg;
    assign image_offset = img_reg;
    assign psf_index    = psf_reg;
    assign span_cols    = nj2_reg;
    assign span_rows    = ni2_reg;
    assign overlap_case = kind2_reg;

endmodule

`default_nettype wire

@@ rtl/psf_window_clip_unit.sv @@
// Top level of the PSF window clip block: configuration registers and the pipeline.
// Depends on pwc_pkg, pwc_front, pwc_div_pipe and pwc_back.
//
//   channel   direction  handshake            word
//   cfg       in         cfg_we               cfg_addr, cfg_data
//   in        in         in_valid / in_stall  pos_x, pos_y
//   out       out        out_valid / out_stall image_offset, psf_index, spans, case
//
// A new word can enter every cycle while in_stall is low; the pipeline is the one-bit-per-stage
// divider (34 stages) plus one input stage and two output stages.
// Reset clears only the valid bits and loads the register defaults.
// Every stage holds its word while the next one is full and stalled; bubbles close up.
`timescale 1ns / 1ps
`default_nettype none

module psf_window_clip_unit
    import pwc_pkg::*;
#(
    parameter int IMAGE_COLS = DEF_IMAGE_COLS,
    parameter int IMAGE_ROWS = DEF_IMAGE_ROWS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [CFG_D_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [19:0]             image_offset,
    output logic [15:0]             psf_index,
    output logic [10:0]             span_cols,
    output logic [10:0]             span_rows,
    output logic [CASE_W-1:0]       overlap_case
);

    pwc_cfg_t                  cfg_reg;
    logic [LANES-1:0][DEN_W-1:0] den;
    logic [30:0]               px_eff;
    logic [30:0]               py_eff;
    logic                      f_valid;
    logic                      f_stall;
    pwc_num_t                  f_num;
    logic [CASE_W-1:0]         f_kind;
    logic                      d_valid;
    logic                      d_stall;
    pwc_num_t                  d_quo;
    logic [CASE_W-1:0]         d_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.pitch_x    <= 31'd65536;
            cfg_reg.pitch_y    <= 31'd65536;
            cfg_reg.psf_cols   <= 9'd50;
            cfg_reg.psf_rows   <= 9'd50;
            cfg_reg.psf_width  <= 31'd3276800;
            cfg_reg.psf_height <= 31'd3276800;
        end
        else if (cfg_we)
        begin
            case (pwc_reg_t'(cfg_addr))
                REG_ORIGIN_X:   cfg_reg.origin_x   <= cfg_data;
                REG_ORIGIN_Y:   cfg_reg.origin_y   <= cfg_data;
                REG_PITCH_X:    cfg_reg.pitch_x    <= cfg_data[30:0];
                REG_PITCH_Y:    cfg_reg.pitch_y    <= cfg_data[30:0];
                REG_PSF_COLS:   cfg_reg.psf_cols   <= cfg_data[8:0];
                REG_PSF_ROWS:   cfg_reg.psf_rows   <= cfg_data[8:0];
                REG_PSF_WIDTH:  cfg_reg.psf_width  <= cfg_data[30:0];
                REG_PSF_HEIGHT: cfg_reg.psf_height <= cfg_data[30:0];
                default:        cfg_reg.origin_x   <= cfg_reg.origin_x;
            endcase
        end
    end

    // A pitch of zero behaves as the smallest pitch.
    assign px_eff = (cfg_reg.pitch_x == '0) ? 31'd1 : cfg_reg.pitch_x;
    assign py_eff = (cfg_reg.pitch_y == '0) ? 31'd1 : cfg_reg.pitch_y;
    assign den[0] = {px_eff, 1'b0};
    assign den[1] = {px_eff, 1'b0};
    assign den[2] = {py_eff, 1'b0};
    assign den[3] = {py_eff, 1'b0};

    pwc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .out_valid (f_valid),
        .out_stall (f_stall),
        .num       (f_num),
        .kind      (f_kind)
    );

    pwc_div_pipe #(
        .N_W  (NUM_W),
        .D_W  (DEN_W),
        .NL   (LANES),
        .SB_W (CASE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .den       (den),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .num       (f_num),
        .sb_in     (f_kind),
        .out_valid (d_valid),
        .out_stall (d_stall),
        .quo       (d_quo),
        .sb_out    (d_kind)
    );

    pwc_back #(
        .IMAGE_COLS (IMAGE_COLS),
        .IMAGE_ROWS (IMAGE_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (d_valid),
        .in_stall     (d_stall),
        .quo          (d_quo),
        .kind         (d_kind),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .image_offset (image_offset),
        .psf_index    (psf_index),
        .span_cols    (span_cols),
        .span_rows    (span_rows),
        .overlap_case (overlap_case)
    );

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (overlap_case == CASE_NONE) |->
        (image_offset == '0) && (psf_index == '0) && (span_cols == '0) && (span_rows == '0))
        else $error("no-overlap word carries nonzero fields");

    a_corner_img: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (overlap_case == CASE_CORNER) |-> (image_offset == '0))
        else $error("corner case with nonzero image offset");

    a_inside_psf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (overlap_case == CASE_INSIDE) |-> (psf_index == '0))
        else $error("PSF-inside case with nonzero PSF index");

    a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid && d_stall |=> d_valid)
        else $error("divider output lost while the back end stalled");

endmodule

`default_nettype wire
